>>> rtl/lst_pkg.sv
// Shared constants, register codes and handshake types of the lane tracker.
package lst_pkg;

  // Default geometry of one camera line and of the lane search.
  localparam int LINE_PIXELS_DEF  = 128;
  localparam int SEARCH_STEPS_DEF = 25;
  localparam int EDGE_MARGIN_DEF  = 15;

  // Width of one pixel and half width of the neighbour window.
  localparam int PIX_W    = 8;
  localparam int WIN_HALF = 3;

  // Depth of the line queue between the front end and the back end.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register codes and reset values.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DARK_OFFSET   = 2'd0,
    CFG_CENTRE_COLUMN = 2'd1,
    CFG_DEFAULT_LEFT  = 2'd2,
    CFG_DEFAULT_RIGHT = 2'd3
  } cfg_idx_t;

  localparam logic [PIX_W-1:0] DARK_OFFSET_RST = 8'd30;
  localparam int CENTRE_COLUMN_RST = 61;
  localparam int DEFAULT_LEFT_RST  = 20;
  localparam int DEFAULT_RIGHT_RST = 102;

  // Servo compare: base value at straight ahead, slope as a shift, and the
  // column offset at which the steering limits are reached.
  localparam int STEER_W = 13;
  localparam logic [STEER_W-1:0] STEER_BASE = 13'd5440;
  localparam int STEER_SHIFT = 7;
  localparam int STEER_LIMIT = 10;

  // A finished line buffer, named by its bank.
  typedef struct packed {
    logic vld;
    logic bank;
  } line_tok_t;

endpackage

>>> rtl/lst_front.sv
// Front end: accepts pixels, fills the two line buffers and announces full lines.
module lst_front #(
  parameter int LINE_PIXELS = lst_pkg::LINE_PIXELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lst_pkg::PIX_W-1:0]         in_pixel,
  output lst_pkg::line_tok_t                push,
  input  logic                              q_full,
  input  logic                              rd_en,
  input  logic                              rd_bank,
  input  logic [$clog2(LINE_PIXELS)-1:0]    rd_col,
  output logic [lst_pkg::PIX_W-1:0]         rd_data
);
  import lst_pkg::*;

  localparam int CW = $clog2(LINE_PIXELS);

  logic [PIX_W-1:0] pix_mem [2][LINE_PIXELS];
  logic [CW-1:0]    idx_r;
  logic             bank_r;
  logic             accept;
  logic             line_end;
  logic [PIX_W-1:0] rd_data_r;

  // Both banks are taken while the queue is full: hold the camera off.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign line_end = (idx_r == CW'(LINE_PIXELS - 1));

  // A line is handed over on the transaction that carries its last pixel.
  assign push.vld  = accept && line_end;
  assign push.bank = bank_r;

  // Column counter and bank select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      bank_r <= 1'b0;
    end else if (accept) begin
      if (line_end) begin
        idx_r  <= '0;
        bank_r <= !bank_r;
      end else begin
        idx_r <= idx_r + CW'(1);
      end
    end
  end

  // Line buffers: written by the camera side, read by the back end.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_mem[bank_r][idx_r] <= in_pixel;
    end
    if (rd_en) begin
      rd_data_r <= pix_mem[rd_bank][rd_col];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/lst_queue.sv
// Short queue of finished line buffers between the front end and the back end.
module lst_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  lst_pkg::line_tok_t push,
  input  logic               pop,
  output lst_pkg::line_tok_t head,
  output logic               full
);
  import lst_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             bank_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign do_push  = push.vld && !full;
  assign do_pop   = pop && (cnt_r != '0);
  assign head.vld  = (cnt_r != '0);
  assign head.bank = bank_q[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      bank_q[wr_ptr_r] <= push.bank;
    end
  end

endmodule

>>> rtl/lst_back.sv
// Back end: binarizes a stored line, searches both lanes and forms the result.
module lst_back #(
  parameter int LINE_PIXELS  = lst_pkg::LINE_PIXELS_DEF,
  parameter int SEARCH_STEPS = lst_pkg::SEARCH_STEPS_DEF,
  parameter int EDGE_MARGIN  = lst_pkg::EDGE_MARGIN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lst_pkg::line_tok_t                tok,
  output logic                              tok_pop,
  output logic                              rd_en,
  output logic                              rd_bank,
  output logic [$clog2(LINE_PIXELS)-1:0]    rd_col,
  input  logic [lst_pkg::PIX_W-1:0]         rd_data,
  input  logic [lst_pkg::PIX_W-1:0]         dark_offset,
  input  logic [$clog2(LINE_PIXELS)-1:0]    centre_column,
  input  logic [$clog2(LINE_PIXELS)-1:0]    default_left,
  input  logic [$clog2(LINE_PIXELS)-1:0]    default_right,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [$clog2(LINE_PIXELS)-1:0]    out_left_lane,
  output logic [$clog2(LINE_PIXELS)-1:0]    out_right_lane,
  output logic                              out_left_found,
  output logic                              out_right_found,
  output logic [lst_pkg::STEER_W-1:0]       out_steer_compare
);
  import lst_pkg::*;

  localparam int CW = $clog2(LINE_PIXELS);
  localparam int IW = (SEARCH_STEPS > 1) ? $clog2(SEARCH_STEPS) : 1;
  localparam int PW = ((CW > IW) ? CW : IW) + 1;
  localparam int XW = CW + 2;
  localparam int SUM_W = PIX_W + 3;
  localparam int THR_W = PIX_W + 4;
  localparam int WIN_N = 2 * WIN_HALF + 1;

  localparam logic [CW-1:0] COL_LO  = CW'(EDGE_MARGIN);
  localparam logic [CW-1:0] COL_HI  = CW'(LINE_PIXELS - EDGE_MARGIN);
  localparam logic [PW-1:0] PRB_LO  = PW'(EDGE_MARGIN);
  localparam logic [PW-1:0] PRB_HI  = PW'(LINE_PIXELS - EDGE_MARGIN);
  localparam logic [CW-1:0] COL_MAX = CW'(LINE_PIXELS - 1);
  localparam logic signed [CW:0] LIM_P = (CW + 1)'(STEER_LIMIT);
  localparam logic signed [CW:0] LIM_N = -((CW + 1)'(STEER_LIMIT));

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIN,
    S_SRCH,
    S_FIX,
    S_OUT
  } state_t;

  state_t state_r;

  // Binarization pipeline.
  logic             bank_r;
  logic             rd_act_r;
  logic [CW-1:0]    rd_col_r;
  logic             rd_vld_r;
  logic [CW-1:0]    rc_r;
  logic             win_vld_r;
  logic [PIX_W-1:0] win_r [WIN_N];
  logic [CW-1:0]    win_col_r;
  logic [CW-1:0]    ctr_col;
  logic             ctr_in;
  logic             b_wr_r;
  logic [CW-1:0]    b_col_r;
  logic [SUM_W-1:0] sum_r;
  logic [THR_W-1:0] thr_r;
  logic [PIX_W:0]   thr_base;
  logic             dark_mem [LINE_PIXELS];

  // Lane search.
  logic             lane_sel_r;
  logic             iss_act_r;
  logic [IW-1:0]    iss_i_r;
  logic             ev_vld_r;
  logic [IW-1:0]    ev_i_r;
  logic             dk_p_r;
  logic             dk_m_r;
  logic             rng_p_r;
  logic             rng_m_r;
  logic [CW-1:0]    base;
  logic [PW-1:0]    prb_p;
  logic [PW-1:0]    prb_m;
  logic             ok_p;
  logic             ok_m;
  logic             hit_p;
  logic             hit_m;
  logic             lane_done;
  logic [CW-1:0]    new_pos;
  logic signed [IW:0] new_gap;

  // Lane state and line results.
  logic [CW-1:0]    left_pos_r;
  logic [CW-1:0]    right_pos_r;
  logic             lf_r;
  logic             rf_r;
  logic signed [IW:0] lgap_r;
  logic signed [IW:0] rgap_r;
  logic [CW-1:0]    fix_l;
  logic [CW-1:0]    fix_r;

  // Steering and output stage.
  logic [CW:0]         pos_sum;
  logic [CW-1:0]       mid;
  logic signed [CW:0]  diff;
  logic signed [CW:0]  diff_c;
  logic signed [STEER_W-1:0] steer_off;
  logic [STEER_W-1:0]  steer;
  logic                out_load;
  logic                out_valid_r;
  logic [CW-1:0]       out_l_r;
  logic [CW-1:0]       out_r_r;
  logic                out_lf_r;
  logic                out_rf_r;
  logic [STEER_W-1:0]  out_steer_r;

  // Lane moved by the other lane's gap, held inside the line.
  function automatic logic [CW-1:0] shift_col(input logic [CW-1:0] pos,
                                              input logic signed [IW:0] gap);
    logic signed [XW-1:0] s;
    s = $signed({2'b00, pos}) + XW'(gap);
    if (s < 0) begin
      return '0;
    end else if (s > $signed({2'b00, COL_MAX})) begin
      return COL_MAX;
    end
    return s[CW-1:0];
  endfunction

  // Line buffer reads are issued one column per cycle.
  assign rd_en   = (state_r == S_BIN) && rd_act_r;
  assign rd_bank = bank_r;
  assign rd_col  = rd_col_r;
  // The bank is released with its last read.
  assign tok_pop = rd_en && (rd_col_r == COL_MAX);

  // Centre of the neighbour window and its edge test.
  assign ctr_col  = win_col_r - CW'(WIN_HALF);
  assign ctr_in   = (ctr_col >= COL_LO) && (ctr_col < COL_HI);
  assign thr_base = {1'b0, win_r[WIN_HALF]} + {1'b0, dark_offset} + (PIX_W + 1)'(1);

  // Probe addresses for step i on both sides of the stored position.
  always_comb begin
    base  = lane_sel_r ? right_pos_r : left_pos_r;
    prb_p = PW'(base) + PW'(iss_i_r);
    prb_m = PW'(base) - PW'(iss_i_r);
    ok_p  = (prb_p >= PRB_LO) && (prb_p < PRB_HI);
    ok_m  = (PW'(iss_i_r) <= PW'(base)) && (prb_m >= PRB_LO) && (prb_m < PRB_HI);
  end

  // Evaluation of the registered probe; the plus side wins a tie.
  always_comb begin
    hit_p     = ev_vld_r && rng_p_r && dk_p_r;
    hit_m     = ev_vld_r && rng_m_r && dk_m_r;
    lane_done = hit_p || hit_m || (ev_vld_r && (ev_i_r == IW'(SEARCH_STEPS - 1)));
    if (hit_p) begin
      new_pos = base + CW'(ev_i_r);
      new_gap = $signed({1'b0, ev_i_r});
    end else if (hit_m) begin
      new_pos = base - CW'(ev_i_r);
      new_gap = -$signed({1'b0, ev_i_r});
    end else begin
      new_pos = base;
      new_gap = '0;
    end
  end

  // Lost lane follows the found one; coinciding lanes go back to defaults.
  always_comb begin
    fix_l = left_pos_r;
    fix_r = right_pos_r;
    if (!lf_r && rf_r) begin
      fix_l = shift_col(left_pos_r, rgap_r);
    end else if (lf_r && !rf_r) begin
      fix_r = shift_col(right_pos_r, lgap_r);
    end
    if (fix_l == fix_r) begin
      fix_l = default_left;
      fix_r = default_right;
    end
  end

  // Servo compare from the lane midpoint, clamped at the steering limits.
  always_comb begin
    pos_sum = {1'b0, left_pos_r} + {1'b0, right_pos_r};
    mid     = pos_sum[CW:1];
    diff    = $signed({1'b0, mid}) - $signed({1'b0, centre_column});
    if (diff > LIM_P) begin
      diff_c = LIM_P;
    end else if (diff < LIM_N) begin
      diff_c = LIM_N;
    end else begin
      diff_c = diff;
    end
    steer_off = STEER_W'(diff_c) <<< STEER_SHIFT;
    steer     = STEER_BASE + $unsigned(steer_off);
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bank_r      <= 1'b0;
      rd_act_r    <= 1'b0;
      rd_col_r    <= '0;
      rd_vld_r    <= 1'b0;
      win_vld_r   <= 1'b0;
      b_wr_r      <= 1'b0;
      lane_sel_r  <= 1'b0;
      iss_act_r   <= 1'b0;
      iss_i_r     <= '0;
      ev_vld_r    <= 1'b0;
      left_pos_r  <= '0;
      right_pos_r <= '0;
      lf_r        <= 1'b0;
      rf_r        <= 1'b0;
      lgap_r      <= '0;
      rgap_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r  <= rd_en;
      win_vld_r <= rd_vld_r;
      b_wr_r    <= win_vld_r && ctr_in;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (tok.vld) begin
            bank_r   <= tok.bank;
            rd_act_r <= 1'b1;
            rd_col_r <= '0;
            state_r  <= S_BIN;
          end
        end
        S_BIN: begin
          if (rd_act_r) begin
            if (rd_col_r == COL_MAX) begin
              rd_act_r <= 1'b0;
            end else begin
              rd_col_r <= rd_col_r + CW'(1);
            end
          end else if (!rd_vld_r && !win_vld_r && !b_wr_r) begin
            lane_sel_r <= 1'b0;
            iss_act_r  <= 1'b1;
            iss_i_r    <= '0;
            ev_vld_r   <= 1'b0;
            state_r    <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (lane_done) begin
            ev_vld_r  <= 1'b0;
            iss_act_r <= 1'b1;
            iss_i_r   <= '0;
            if (!lane_sel_r) begin
              left_pos_r <= new_pos;
              lf_r       <= hit_p || hit_m;
              lgap_r     <= new_gap;
              lane_sel_r <= 1'b1;
            end else begin
              right_pos_r <= new_pos;
              rf_r        <= hit_p || hit_m;
              rgap_r      <= new_gap;
              iss_act_r   <= 1'b0;
              state_r     <= S_FIX;
            end
          end else begin
            ev_vld_r <= iss_act_r;
            if (iss_act_r) begin
              if (iss_i_r == IW'(SEARCH_STEPS - 1)) begin
                iss_act_r <= 1'b0;
              end else begin
                iss_i_r <= iss_i_r + IW'(1);
              end
            end
          end
        end
        S_FIX: begin
          left_pos_r  <= fix_l;
          right_pos_r <= fix_r;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Neighbour window, threshold stage and dark map writes.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rc_r <= rd_col_r;
    end
    if (rd_vld_r) begin
      for (int k = 0; k < WIN_N - 1; k++) begin
        win_r[k] <= win_r[k + 1];
      end
      win_r[WIN_N-1] <= rd_data;
      win_col_r      <= rc_r;
    end
    b_col_r <= ctr_col;
    sum_r   <= SUM_W'(win_r[0]) + SUM_W'(win_r[1]) + SUM_W'(win_r[2]) +
               SUM_W'(win_r[4]) + SUM_W'(win_r[5]) + SUM_W'(win_r[6]);
    // Dark when floor(sum / 6) - offset > pixel, i.e. sum >= 6 * (pixel + offset + 1).
    thr_r   <= THR_W'({thr_base, 2'b00}) + THR_W'({thr_base, 1'b0});
    if (b_wr_r) begin
      dark_mem[b_col_r] <= ({1'b0, sum_r} >= thr_r);
    end
  end

  // Two registered dark map reads per search step.
  always_ff @(posedge clk) begin
    dk_p_r  <= dark_mem[prb_p[CW-1:0]];
    dk_m_r  <= dark_mem[prb_m[CW-1:0]];
    rng_p_r <= ok_p;
    rng_m_r <= ok_m;
    ev_i_r  <= iss_i_r;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_l_r     <= left_pos_r;
      out_r_r     <= right_pos_r;
      out_lf_r    <= lf_r;
      out_rf_r    <= rf_r;
      out_steer_r <= steer;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_lane     = out_l_r;
  assign out_right_lane    = out_r_r;
  assign out_left_found    = out_lf_r;
  assign out_right_found   = out_rf_r;
  assign out_steer_compare = out_steer_r;

endmodule

>>> rtl/line_scan_lane_tracker.sv
// Top level of the line-scan lane tracker: configuration registers and the three units.
//
// Pixels of one camera line enter on the in_ channel, one per transaction, in column
// order. They are written into one of two line buffers at one pixel per cycle while
// in_stall is low. After the last pixel of a line, the back end binarizes the stored
// line in one pass (one buffer read per cycle), then searches the left and then the
// right lane (two dark map reads per step), settles the lanes and loads the result
// register. One out_ transaction per line carries the lanes, found flags and servo
// compare. The front end keeps taking pixels of the next line while a line is
// processed; it stalls only when both line buffers wait for the back end.
// When out_stall is high while out_valid is high, the result register holds, the
// back end waits in its output state, and the input stalls once both buffers are full.
// Reset (synchronous, rst_n low) clears the column counter, the queue, the lane
// positions to column 0 and loads the register defaults; line buffers need no clearing.
// Configuration writes are always accepted (cfg_ready is high) and must be made
// while no line is in work.
module line_scan_lane_tracker #(
  parameter int LINE_PIXELS  = lst_pkg::LINE_PIXELS_DEF,
  parameter int SEARCH_STEPS = lst_pkg::SEARCH_STEPS_DEF,
  parameter int EDGE_MARGIN  = lst_pkg::EDGE_MARGIN_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [lst_pkg::PIX_W-1:0]             in_pixel,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [$clog2(LINE_PIXELS)-1:0]        out_left_lane,
  output logic [$clog2(LINE_PIXELS)-1:0]        out_right_lane,
  output logic                                  out_left_found,
  output logic                                  out_right_found,
  output logic [lst_pkg::STEER_W-1:0]           out_steer_compare,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lst_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [(($clog2(LINE_PIXELS) > lst_pkg::PIX_W) ?
                 $clog2(LINE_PIXELS) : lst_pkg::PIX_W)-1:0] cfg_data
);
  import lst_pkg::*;

  localparam int CW = $clog2(LINE_PIXELS);

  logic [PIX_W-1:0] dark_offset_r;
  logic [CW-1:0]    centre_column_r;
  logic [CW-1:0]    default_left_r;
  logic [CW-1:0]    default_right_r;
  line_tok_t        push;
  line_tok_t        head;
  logic             q_full;
  logic             tok_pop;
  logic             rd_en;
  logic             rd_bank;
  logic [CW-1:0]    rd_col;
  logic [PIX_W-1:0] rd_data;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_offset_r   <= DARK_OFFSET_RST;
      centre_column_r <= CW'(CENTRE_COLUMN_RST);
      default_left_r  <= CW'(DEFAULT_LEFT_RST);
      default_right_r <= CW'(DEFAULT_RIGHT_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DARK_OFFSET:   dark_offset_r   <= cfg_data[PIX_W-1:0];
        CFG_CENTRE_COLUMN: centre_column_r <= cfg_data[CW-1:0];
        CFG_DEFAULT_LEFT:  default_left_r  <= cfg_data[CW-1:0];
        CFG_DEFAULT_RIGHT: default_right_r <= cfg_data[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  lst_front #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pixel (in_pixel),
    .push     (push),
    .q_full   (q_full),
    .rd_en    (rd_en),
    .rd_bank  (rd_bank),
    .rd_col   (rd_col),
    .rd_data  (rd_data)
  );

  lst_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (tok_pop),
    .head  (head),
    .full  (q_full)
  );

  lst_back #(
    .LINE_PIXELS  (LINE_PIXELS),
    .SEARCH_STEPS (SEARCH_STEPS),
    .EDGE_MARGIN  (EDGE_MARGIN)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .tok               (head),
    .tok_pop           (tok_pop),
    .rd_en             (rd_en),
    .rd_bank           (rd_bank),
    .rd_col            (rd_col),
    .rd_data           (rd_data),
    .dark_offset       (dark_offset_r),
    .centre_column     (centre_column_r),
    .default_left      (default_left_r),
    .default_right     (default_right_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_lane     (out_left_lane),
    .out_right_lane    (out_right_lane),
    .out_left_found    (out_left_found),
    .out_right_found   (out_right_found),
    .out_steer_compare (out_steer_compare)
  );

endmodule

>>> tb/sv/tb_line_scan_lane_tracker.sv
// Self-checking testbench of the line-scan lane tracker: directed lines, random lines, checker.
`timescale 1ns / 100ps

module tb_line_scan_lane_tracker;
  import lst_pkg::*;

  localparam int LINE = LINE_PIXELS_DEF;
  localparam int STEPS = SEARCH_STEPS_DEF;
  localparam int MARGIN = EDGE_MARGIN_DEF;
  localparam int COL_W = $clog2(LINE);
  localparam int STEER_LO = int'(STEER_BASE) - (STEER_LIMIT << STEER_SHIFT);
  localparam int STEER_HI = int'(STEER_BASE) + (STEER_LIMIT << STEER_SHIFT);
  localparam int DRAIN_CYCLES = LINE + 2 * STEPS + 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES = 6;
  localparam int LINES_PER_PHASE = 8;
  localparam int DIR_ROWS = 17;

  // One line result as it leaves the block.
  typedef struct packed {
    logic [COL_W-1:0]   left_lane;
    logic [COL_W-1:0]   right_lane;
    logic               left_found;
    logic               right_found;
    logic [STEER_W-1:0] steer;
  } lane_result_t;

  // One directed line: optional register settings, a flat background with up to two
  // marks, and a hand-typed result where it is obvious.
  typedef struct packed {
    bit set_regs;
    int off;
    int cen;
    int def_l;
    int def_r;
    int bg;
    int ink;
    int lcol;
    int lwid;
    int rcol;
    int rwid;
    bit known;
    int exp_l;
    int exp_r;
    int exp_lf;
    int exp_rf;
    int exp_steer;
  } line_row_t;

  // Block ports.
  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [PIX_W-1:0]   in_pixel;
  logic               out_valid;
  logic               out_stall;
  logic [COL_W-1:0]   out_left_lane;
  logic [COL_W-1:0]   out_right_lane;
  logic               out_left_found;
  logic               out_right_found;
  logic [STEER_W-1:0] out_steer_compare;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PIX_W-1:0]   cfg_data;

  // Tracker model state and its copy of the registers.
  logic [PIX_W-1:0] line_buf [LINE];
  bit               dark_col [LINE];
  int               left_pos;
  int               right_pos;
  int               col_cnt;
  int               reg_offset;
  int               reg_centre;
  int               reg_def_l;
  int               reg_def_r;

  // Stimulus and bookkeeping.
  lane_result_t     pending_lanes [$];
  logic [PIX_W-1:0] line_px [LINE];
  line_row_t        dir_rows [DIR_ROWS];
  int               burst_left;
  int               errors;
  int               results_seen;
  int               pixels_sent;
  int               lines_sent;
  int               reg_writes;
  int               quiet_cycles;
  int               stall_win;
  int               stall_mode;

  wire in_fire  = in_valid & ~in_stall;
  wire out_fire = out_valid & ~out_stall;
  wire cfg_fire = cfg_valid & cfg_ready;

  line_scan_lane_tracker i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_lane     (out_left_lane),
    .out_right_lane    (out_right_lane),
    .out_left_found    (out_left_found),
    .out_right_found   (out_right_found),
    .out_steer_compare (out_steer_compare),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #4 clk = ~clk;

  // A column is dark only inside the line and where the binarized map says so.
  function automatic bit dark_at(input int col);
    if (col < 0 || col > LINE - 1) return 1'b0;
    return dark_col[col];
  endfunction

  // Search outward from a lane position for the nearest dark column.
  function automatic bit seek_mark(inout int pos, output int gap);
    gap = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (dark_at(pos + i)) begin
        pos += i;
        gap = i;
        return 1'b1;
      end
      if (dark_at(pos - i)) begin
        pos -= i;
        gap = -i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int clamp_col(input int v);
    if (v < 0) return 0;
    if (v > LINE - 1) return LINE - 1;
    return v;
  endfunction

  // Store one pixel; on the last pixel of a line, binarize, track the lanes and
  // return the line result.
  function automatic bit scan_pixel(input logic [PIX_W-1:0] pix, output lane_result_t res);
    int  sum;
    int  lgap;
    int  rgap;
    int  mid;
    int  cmp;
    bit  lf;
    bit  rf;
    line_buf[col_cnt] = pix;
    if (col_cnt < LINE - 1) begin
      col_cnt++;
      return 1'b0;
    end
    col_cnt = 0;

    // A pixel is dark when the neighbour mean less the offset is above it.
    for (int c = 0; c < LINE; c++) dark_col[c] = 1'b0;
    for (int c = MARGIN; c < LINE - MARGIN; c++) begin
      sum = line_buf[c-3] + line_buf[c-2] + line_buf[c-1] +
            line_buf[c+1] + line_buf[c+2] + line_buf[c+3];
      if (sum / 6 - reg_offset > int'(line_buf[c])) dark_col[c] = 1'b1;
    end

    lf = seek_mark(left_pos, lgap);
    rf = seek_mark(right_pos, rgap);
    // A lost lane follows the shift of the lane that was found.
    if (!lf && rf) left_pos = clamp_col(left_pos + rgap);
    else if (lf && !rf) right_pos = clamp_col(right_pos + lgap);
    if (left_pos == right_pos) begin
      left_pos  = reg_def_l;
      right_pos = reg_def_r;
    end

    mid = (left_pos + right_pos) / 2;
    cmp = int'(STEER_BASE) + (mid - reg_centre) * (1 << STEER_SHIFT);
    if (cmp > STEER_HI) cmp = STEER_HI;
    if (cmp < STEER_LO) cmp = STEER_LO;

    res.left_lane   = left_pos[COL_W-1:0];
    res.right_lane  = right_pos[COL_W-1:0];
    res.left_found  = lf;
    res.right_found = rf;
    res.steer       = cmp[STEER_W-1:0];
    return 1'b1;
  endfunction

  // Build a line from a noisy background and up to two marks.
  task automatic build_line(input int bg, input int noise, input int ink,
                            input int lcol, input int lwid, input int rcol, input int rwid);
    int v;
    for (int c = 0; c < LINE; c++) begin
      v = bg;
      if (noise > 0) v = bg + int'($urandom_range(0, 2 * noise)) - noise;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      line_px[c] = v[PIX_W-1:0];
    end
    for (int c = lcol; c < lcol + lwid; c++)
      if (c >= 0 && c < LINE) line_px[c] = ink[PIX_W-1:0];
    for (int c = rcol; c < rcol + rwid; c++)
      if (c >= 0 && c < LINE) line_px[c] = ink[PIX_W-1:0];
  endtask

  // Drive one line, one pixel per transaction, in bursts with random gaps.
  task automatic send_line(input bit known, input lane_result_t typed_res);
    int           gap;
    lane_result_t got;
    for (int c = 0; c < LINE; c++) begin
      @(negedge clk);
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 200);
      end
      in_valid <= 1'b1;
      in_pixel <= line_px[c];
      burst_left--;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      pixels_sent++;
      if (scan_pixel(line_px[c], got)) pending_lanes.push_back(known ? typed_res : got);
    end
    lines_sent++;
  endtask

  // Hold the input until every expected line result is out and the block is quiet.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_lanes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers, one transaction each.
  task automatic write_regs(input int v_off, input int v_cen, input int v_dl, input int v_dr);
    cfg_idx_t idx;
    int       v;
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        CFG_DARK_OFFSET:   v = v_off;
        CFG_CENTRE_COLUMN: v = v_cen;
        CFG_DEFAULT_LEFT:  v = v_dl;
        default:           v = v_dr;
      endcase
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= v[PIX_W-1:0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        CFG_DARK_OFFSET:   reg_offset = v & 8'hFF;
        CFG_CENTRE_COLUMN: reg_centre = v & 7'h7F;
        CFG_DEFAULT_LEFT:  reg_def_l  = v & 7'h7F;
        default:           reg_def_r  = v & 7'h7F;
      endcase
      reg_writes++;
      idx = idx.next();
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random register value: an extreme now and then, otherwise a working value.
  function automatic int pick_reg(input int lo, input int hi, input int top);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return top;
      default: return int'($urandom_range(lo, hi));
    endcase
  endfunction

  // Random line, mostly two marks near the tracked lanes, plus noise and traps.
  task automatic random_line();
    int kind;
    int bg;
    int ink;
    int lcol;
    int rcol;
    int lwid;
    int rwid;
    kind = $urandom_range(0, 9);
    bg   = $urandom_range(40, 255);
    ink  = $urandom_range(0, bg / 3);
    if (kind == 0) begin
      // Pure noise over the whole pixel range.
      foreach (line_px[c]) line_px[c] = $urandom_range(0, 255);
    end else if (kind == 1) begin
      // One mark between the lanes, so both may lock onto it, and one at the border.
      build_line(bg, $urandom_range(0, 4), ink, (left_pos + right_pos) / 2,
                 $urandom_range(1, 2), $urandom_range(0, 1) ? $urandom_range(0, 14) :
                 $urandom_range(LINE - MARGIN, LINE - 1), $urandom_range(1, 4));
    end else begin
      lcol = left_pos + int'($urandom_range(0, 60)) - 30;
      rcol = right_pos + int'($urandom_range(0, 60)) - 30;
      lwid = ($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, 3));
      rwid = ($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, 3));
      build_line(bg, $urandom_range(0, 6), ink, lcol, lwid, rcol, rwid);
    end
    send_line(1'b0, '0);
  endtask

  // Compare one result field and report a mismatch.
  task automatic check_field(input string what, input logic [STEER_W-1:0] want,
                             input logic [STEER_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Result checker: each accepted transaction against the oldest expected result.
  always @(posedge clk) begin
    lane_result_t want;
    if (rst_n && out_fire) begin
      if (pending_lanes.size() == 0) begin
        errors++;
        $display("%0t ns: lane result with nothing expected, left %0d right %0d",
                 $time, out_left_lane, out_right_lane);
      end else begin
        want = pending_lanes.pop_front();
        results_seen++;
        check_field("left_lane", want.left_lane, out_left_lane);
        check_field("right_lane", want.right_lane, out_right_lane);
        check_field("left_found", want.left_found, out_left_found);
        check_field("right_found", want.right_found, out_right_found);
        check_field("steer_compare", want.steer, out_steer_compare);
      end
    end
  end

  // Receiver stalls: windows of no stall, random stall and mostly stalled.
  always @(negedge clk) begin
    if (stall_win == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_win  = $urandom_range(32, 256);
    end
    stall_win--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (in_fire || out_fire || cfg_fire) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Main sequence: reset, directed lines, random phases, drain and verdict.
  initial begin
    lane_result_t typed_res;
    line_row_t    row;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_pixel     = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_DARK_OFFSET;
    cfg_data     = '0;
    stall_win    = 0;
    stall_mode   = 0;
    quiet_cycles = 0;
    burst_left   = 0;
    errors       = 0;
    results_seen = 0;
    pixels_sent  = 0;
    lines_sent   = 0;
    reg_writes   = 0;

    left_pos   = 0;
    right_pos  = 0;
    col_cnt    = 0;
    reg_offset = int'(DARK_OFFSET_RST);
    reg_centre = CENTRE_COLUMN_RST;
    reg_def_l  = DEFAULT_LEFT_RST;
    reg_def_r  = DEFAULT_RIGHT_RST;

    // set, off, cen, def_l, def_r, bg, ink, lcol, lwid, rcol, rwid,
    // known, left, right, left_found, right_found, steer
    dir_rows = '{
      // Flat line after reset: lanes at column 0 coincide and fall back to defaults.
      '{0, 0, 0, 0, 0, 128, 0, 0, 0, 0, 0, 1, 20, 102, 0, 0, 5312 + 128},
      // Full-scale contrast, one mark within reach of each lane.
      '{0, 0, 0, 0, 0, 255, 0, 30, 1, 90, 1, 1, 30, 90, 1, 1, 5312},
      '{0, 0, 0, 0, 0, 200, 100, 40, 2, 80, 1, 0, 0, 0, 0, 0, 0},
      // Right lane lost, then left lane lost: the other lane follows.
      '{0, 0, 0, 0, 0, 200, 100, 52, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 200, 100, 0, 0, 100, 1, 0, 0, 0, 0, 0, 0},
      // Marks only in the border columns, which always count as bright.
      '{0, 0, 0, 0, 0, 255, 0, 5, 3, 118, 4, 0, 0, 0, 0, 0, 0},
      // Dim background: the threshold goes below zero and nothing is dark.
      '{0, 0, 0, 0, 0, 20, 0, 60, 1, 100, 1, 0, 0, 0, 0, 0, 0},
      // Marks out of search reach.
      '{0, 0, 0, 0, 0, 255, 0, 20, 1, 30, 1, 0, 0, 0, 0, 0, 0},
      // Zero offset, centre at column 0, both defaults at the last column.
      '{1, 0, 0, 127, 127, 100, 99, 70, 1, 110, 1, 0, 0, 0, 0, 0, 0},
      // Both lanes lock onto one mark and fall back to the defaults.
      '{0, 0, 0, 0, 0, 100, 99, 90, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 100, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      // Largest offset: nothing is dark; steering hits its lower limit.
      '{1, 255, 127, 0, 0, 255, 0, 110, 1, 120, 1, 0, 0, 0, 0, 0, 0},
      '{1, 30, 61, 20, 127, 128, 128, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      // A lane moved past the last column saturates there.
      '{0, 0, 0, 0, 0, 255, 0, 34, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 255, 0, 0, 0, 112, 1, 0, 0, 0, 0, 0, 0},
      // A lane moved below column 0 saturates there.
      '{0, 0, 0, 0, 0, 255, 0, 0, 0, 92, 1, 0, 0, 0, 0, 0, 0},
      // First and last columns that can be dark.
      '{0, 0, 0, 0, 0, 255, 0, 15, 1, 112, 1, 0, 0, 0, 0, 0, 0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed lines.
    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      if (row.set_regs) begin
        drain_results();
        write_regs(row.off, row.cen, row.def_l, row.def_r);
      end
      build_line(row.bg, 0, row.ink, row.lcol, row.lwid, row.rcol, row.rwid);
      typed_res.left_lane   = row.exp_l[COL_W-1:0];
      typed_res.right_lane  = row.exp_r[COL_W-1:0];
      typed_res.left_found  = row.exp_lf[0];
      typed_res.right_found = row.exp_rf[0];
      typed_res.steer       = row.exp_steer[STEER_W-1:0];
      send_line(row.known, typed_res);
    end

    // Random phases, each after a full drain and a new register setting.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      write_regs(pick_reg(5, 60, 255), pick_reg(30, 95, 127),
                 pick_reg(5, 60, 127), pick_reg(65, 122, 127));
      for (int n = 0; n < LINES_PER_PHASE; n++) random_line();
    end

    drain_results();
    $display("Sent %0d lines (%0d pixels) under %0d register writes; %0d results checked.",
             lines_sent, pixels_sent, reg_writes, results_seen);
    $display("Mismatches and stray results: %0d, results still awaited: %0d.",
             errors, pending_lanes.size());
    if (errors == 0 && pending_lanes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lst_pkg.sv
rtl/lst_front.sv
rtl/lst_queue.sv
rtl/lst_back.sv
rtl/line_scan_lane_tracker.sv
tb/sv/tb_line_scan_lane_tracker.sv
